FILE: rtl/shfd_pkg.sv
// Package for the sync header frame deframer.
// Frame layout constants, sync header, known identifiers and kind codes.
// No dependencies.
package shfd_pkg;

  localparam int FRAME_BYTES_DEF = 20;
  localparam int POS_W           = 5;
  localparam int ID_BYTES        = 4;
  localparam int PAY_BYTES       = 8;
  localparam int LEN_W           = 4;
  localparam int KIND_W          = 3;

  localparam logic [POS_W-1:0] ID_FIRST  = 5'd5;
  localparam logic [POS_W-1:0] LEN_POS   = 5'd9;
  localparam logic [POS_W-1:0] PAY_FIRST = 5'd10;
  localparam logic [POS_W-1:0] HDR_END   = 5'd4;

  localparam logic [23:0]      SYNC_PREFIX = 24'hAA5501;
  localparam logic [7:0]       SYNC_LAST   = 8'h02;
  localparam logic [LEN_W-1:0] MAX_LEN     = 4'd8;

  localparam logic [31:0] ID_SPEED_BATT = 32'h14520902;
  localparam logic [31:0] ID_AC_TEMP    = 32'h18530904;
  localparam logic [31:0] ID_FAULT      = 32'h1C530902;
  localparam logic [31:0] ID_COMMAND    = 32'h18530905;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPEED_BATT = 3'd0,
    KIND_AC_TEMP    = 3'd1,
    KIND_FAULT      = 3'd2,
    KIND_COMMAND    = 3'd3,
    KIND_UNKNOWN    = 3'd4
  } kind_t;

  function automatic kind_t kind_of(input logic [31:0] id);
    kind_t k;
    if (id == ID_SPEED_BATT)   k = KIND_SPEED_BATT;
    else if (id == ID_AC_TEMP) k = KIND_AC_TEMP;
    else if (id == ID_FAULT)   k = KIND_FAULT;
    else if (id == ID_COMMAND) k = KIND_COMMAND;
    else                       k = KIND_UNKNOWN;
    return k;
  endfunction

endpackage

FILE: rtl/sync_header_frame_deframer.sv
// Top level of the sync header frame deframer; depends on shfd_pkg.
// A frame result appears on m_tvalid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the output register frees in the cycle it is taken,
// so s_tready stays high unless a result is held by m_tready low.
// Reset (rst, synchronous): hunting for the sync header, captures and history cleared,
// no result pending.
module sync_header_frame_deframer
  import shfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // rx_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [103:0]      m_tdata,   // frame_id, payload_len, payload_low, payload_high,
                                       // four pad bits
  output logic [KIND_W-1:0] m_tuser    // frame_kind
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [23:0]          recent_bytes, recent_bytes_next;
  logic                 in_frame, in_frame_next;
  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [31:0]          id_capture, id_capture_next;
  logic [LEN_W-1:0]     length_capture, length_capture_next;
  logic [63:0]          payload_capture, payload_capture_next;
  logic                 accept;
  logic                 frame_done;

  logic [31:0]          out_id;
  logic [LEN_W-1:0]     out_len;
  logic [63:0]          out_payload;
  kind_t                out_kind;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    recent_bytes_next    = recent_bytes;
    in_frame_next        = in_frame;
    byte_position_next   = byte_position;
    id_capture_next      = id_capture;
    length_capture_next  = length_capture;
    payload_capture_next = payload_capture;
    frame_done           = 1'b0;
    if (!in_frame) begin
      if (recent_bytes == SYNC_PREFIX && s_tdata == SYNC_LAST) begin
        in_frame_next        = 1'b1;
        byte_position_next   = HDR_END;
        recent_bytes_next    = '0;
        id_capture_next      = '0;
        length_capture_next  = '0;
        payload_capture_next = '0;
      end else begin
        recent_bytes_next = {recent_bytes[15:0], s_tdata};
      end
    end else begin
      for (int i = 0; i < ID_BYTES; i++) begin
        if (byte_position == ID_FIRST + POS_W'(i)) begin
          id_capture_next[8*i +: 8] = s_tdata;
        end
      end
      if (byte_position == LEN_POS) begin
        length_capture_next = (s_tdata > 8'(MAX_LEN)) ? MAX_LEN : s_tdata[LEN_W-1:0];
      end
      for (int k = 0; k < PAY_BYTES; k++) begin
        if (byte_position == PAY_FIRST + POS_W'(k) && LEN_W'(k) < length_capture) begin
          payload_capture_next[8*k +: 8] = s_tdata;
        end
      end
      if (byte_position >= LAST_POS) begin
        frame_done         = 1'b1;
        in_frame_next      = 1'b0;
        byte_position_next = '0;
        recent_bytes_next  = '0;
      end else begin
        byte_position_next = byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes    <= '0;
      in_frame        <= 1'b0;
      byte_position   <= '0;
      id_capture      <= '0;
      length_capture  <= '0;
      payload_capture <= '0;
    end else if (accept) begin
      recent_bytes    <= recent_bytes_next;
      in_frame        <= in_frame_next;
      byte_position   <= byte_position_next;
      if (frame_done) begin
        id_capture      <= '0;
        length_capture  <= '0;
        payload_capture <= '0;
      end else begin
        id_capture      <= id_capture_next;
        length_capture  <= length_capture_next;
        payload_capture <= payload_capture_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && frame_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_done) begin
      out_id      <= id_capture_next;
      out_len     <= length_capture_next;
      out_payload <= payload_capture_next;
      out_kind    <= kind_of(id_capture_next);
    end
  end

  assign m_tdata = {4'b0000, out_payload, out_len, out_id};
  assign m_tuser = out_kind;

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS)
    else $error("byte position past frame end");

  a_hunt_pos: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_position == '0)
    else $error("position nonzero while hunting");

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    accept && frame_done |=> m_tvalid && !in_frame)
    else $error("frame end did not raise result");

  a_len_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_len <= MAX_LEN)
    else $error("payload length not clamped");
`endif

endmodule

FILE: tb/tb_sync_header_frame_deframer.sv
// Testbench for sync_header_frame_deframer: drives byte streams with framed and stray bytes,
// predicts each frame result and checks it field by field. Depends on shfd_pkg and the RTL top.
module tb_sync_header_frame_deframer;
  import shfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_SIZE   = FRAME_BYTES_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TOTAL_BYTES  = 600;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [31:0] lo;
    logic [31:0] hi;
    kind_t       kind;
  } frame_result_t;

  typedef struct {
    logic [63:0]   lead;
    int            lead_n;
    bit            framed;
    logic [7:0]    b4;
    logic [31:0]   id;
    logic [7:0]    len_byte;
    logic [63:0]   pay;
    logic [15:0]   tail;
    bit            typed;
    frame_result_t res;
  } frame_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;

  sync_header_frame_deframer #(.FRAME_BYTES(FRAME_SIZE)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [23:0] hist;
  bit          collecting;
  logic [4:0]  pos;
  logic [31:0] id_acc;
  logic [3:0]  len_acc;
  logic [63:0] pay_acc;

  frame_result_t pending_frames[$];
  bit            use_typed;
  frame_result_t typed_res;
  int            errors;
  int            frames_predicted;
  int            bytes_sent;
  int            cycles = 0;
  int            burst_left;

  function automatic kind_t id_to_kind(logic [31:0] id);
    case (id)
      ID_SPEED_BATT: return KIND_SPEED_BATT;
      ID_AC_TEMP:    return KIND_AC_TEMP;
      ID_FAULT:      return KIND_FAULT;
      ID_COMMAND:    return KIND_COMMAND;
      default:       return KIND_UNKNOWN;
    endcase
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    int k;
    if (!collecting) begin
      if (hist == SYNC_PREFIX && b == SYNC_LAST) begin
        collecting = 1'b1;
        pos = HDR_END;
        hist = '0;
        id_acc = '0;
        len_acc = '0;
        pay_acc = '0;
      end else begin
        hist = {hist[15:0], b};
      end
    end else begin
      if (pos >= ID_FIRST && pos <= ID_FIRST + 5'd3) begin
        id_acc |= 32'(b) << (8 * (pos - ID_FIRST));
      end else if (pos == LEN_POS) begin
        len_acc = (b > 8'(MAX_LEN)) ? MAX_LEN : b[3:0];
      end else if (pos >= PAY_FIRST && pos <= PAY_FIRST + 5'd7) begin
        k = int'(pos - PAY_FIRST);
        if (k < int'(len_acc)) pay_acc |= 64'(b) << (8 * k);
      end
      if (int'(pos) + 1 >= FRAME_SIZE) begin
        r.id   = id_acc;
        r.len  = len_acc;
        r.lo   = pay_acc[31:0];
        r.hi   = pay_acc[63:32];
        r.kind = id_to_kind(id_acc);
        pending_frames = {pending_frames, (use_typed ? typed_res : r)};
        frames_predicted++;
        collecting = 1'b0;
        pos = '0;
        hist = '0;
        id_acc = '0;
        len_acc = '0;
        pay_acc = '0;
      end else begin
        pos = pos + 5'd1;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_row(input frame_row_t r);
    use_typed = r.typed;
    typed_res = r.res;
    for (int i = r.lead_n - 1; i >= 0; i--) send_byte(r.lead[8*i +: 8]);
    if (r.framed) begin
      send_byte(SYNC_PREFIX[23:16]);
      send_byte(SYNC_PREFIX[15:8]);
      send_byte(SYNC_PREFIX[7:0]);
      send_byte(SYNC_LAST);
      send_byte(r.b4);
      for (int i = 0; i < 4; i++) send_byte(r.id[8*i +: 8]);
      send_byte(r.len_byte);
      for (int i = 0; i < 8; i++) send_byte(r.pay[8*i +: 8]);
      for (int i = 0; i < FRAME_SIZE - 18; i++) send_byte(r.tail[8*i +: 8]);
    end
    use_typed = 1'b0;
  endtask

  function automatic frame_row_t make_row(logic [63:0] lead, int lead_n, bit framed,
                                          logic [7:0] b4, logic [31:0] id, logic [7:0] len_byte,
                                          logic [63:0] pay, logic [15:0] tail, bit typed,
                                          logic [31:0] e_id, logic [3:0] e_len,
                                          logic [31:0] e_lo, logic [31:0] e_hi, kind_t e_kind);
    frame_row_t r;
    r.lead = lead;
    r.lead_n = lead_n;
    r.framed = framed;
    r.b4 = b4;
    r.id = id;
    r.len_byte = len_byte;
    r.pay = pay;
    r.tail = tail;
    r.typed = typed;
    r.res = '{e_id, e_len, e_lo, e_hi, e_kind};
    return r;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return SYNC_PREFIX[23:16];
      1:       return SYNC_PREFIX[15:8];
      2:       return SYNC_PREFIX[7:0];
      3:       return SYNC_LAST;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic frame_row_t random_row();
    frame_row_t r;
    int sel;
    logic [31:0] known[4];
    known = '{ID_SPEED_BATT, ID_AC_TEMP, ID_FAULT, ID_COMMAND};
    r = make_row('0, 0, 1'b1, 8'($urandom), '0, '0, {$urandom, $urandom}, 16'($urandom),
                 1'b0, '0, '0, '0, '0, KIND_UNKNOWN);
    sel = $urandom_range(0, 9);
    if (sel >= 3 && sel < 8) begin
      r.lead_n = $urandom_range(1, 6);
      for (int i = 0; i < r.lead_n; i++) r.lead = {r.lead[55:0], noise_byte()};
    end else if (sel >= 8) begin
      r.lead = {32'd0, SYNC_PREFIX, 8'($urandom)};
      r.lead_n = 4;
    end
    r.framed = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 5))
      0, 1, 2, 3: r.id = known[$urandom_range(0, 3)];
      4:          r.id = known[$urandom_range(0, 3)] ^ (32'd1 << $urandom_range(0, 31));
      default:    r.id = $urandom;
    endcase
    r.len_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    return r;
  endfunction

  // receiver: stall pattern steps through four modes in turn
  always @(posedge clk) begin
    frame_result_t got, want;
    case ((cycles / 300) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= cycles[0];
      2:       m_tready <= $urandom_range(0, 1);
      default: m_tready <= (cycles[2:0] == 3'd0);
    endcase
    if (!rst && m_tvalid && m_tready) begin
      got.id   = m_tdata[31:0];
      got.len  = m_tdata[35:32];
      got.lo   = m_tdata[67:36];
      got.hi   = m_tdata[99:68];
      got.kind = kind_t'(m_tuser);
      if (pending_frames.size() == 0) begin
        $error("frame result with none pending");
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (got.id !== want.id) begin
          $error("frame_id: expected %h, got %h", want.id, got.id);
          errors++;
        end
        if (got.len !== want.len) begin
          $error("payload_len: expected %0d, got %0d", want.len, got.len);
          errors++;
        end
        if (got.lo !== want.lo) begin
          $error("payload_low: expected %h, got %h", want.lo, got.lo);
          errors++;
        end
        if (got.hi !== want.hi) begin
          $error("payload_high: expected %h, got %h", want.hi, got.hi);
          errors++;
        end
        if (got.kind !== want.kind) begin
          $error("frame_kind: expected %0d, got %0d", want.kind, got.kind);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL sync_header_frame_deframer");
      $finish;
    end
  end

  initial begin
    frame_row_t plan[$];
    hist = '0;
    collecting = 1'b0;
    pos = '0;
    id_acc = '0;
    len_acc = '0;
    pay_acc = '0;
    use_typed = 1'b0;
    errors = 0;
    frames_predicted = 0;
    bytes_sent = 0;
    burst_left = 20;

    // all zero, all ones with clamped length
    plan = {plan, make_row('0, 0, 1, 8'h00, '0, 8'h00, '0, 16'h0000,
                           1, '0, 4'd0, '0, '0, KIND_UNKNOWN)};
    plan = {plan, make_row('0, 0, 1, 8'hFF, '1, 8'hFF, '1, 16'hFFFF,
                           1, '1, 4'd8, '1, '1, KIND_UNKNOWN)};
    // known identifiers with full, short, clamped and empty payloads, then an unknown identifier
    plan = {plan, make_row('0, 0, 1, 8'h5A, ID_SPEED_BATT, 8'd8, 64'h0123456789ABCDEF, 16'h1234,
                           1, ID_SPEED_BATT, 4'd8, 32'h89ABCDEF, 32'h01234567,
                           KIND_SPEED_BATT)};
    plan = {plan, make_row('0, 0, 1, 8'h3C, ID_AC_TEMP, 8'd3, 64'h1122334455667788, 16'hABCD,
                           1, ID_AC_TEMP, 4'd3, 32'h00667788, 32'h0, KIND_AC_TEMP)};
    plan = {plan, make_row('0, 0, 1, 8'h00, ID_FAULT, 8'd9, 64'hFEDCBA9876543210, 16'h0,
                           1, ID_FAULT, 4'd8, 32'h76543210, 32'hFEDCBA98, KIND_FAULT)};
    plan = {plan, make_row('0, 0, 1, 8'hFF, ID_COMMAND, 8'd0, '1, 16'hFFFF,
                           1, ID_COMMAND, 4'd0, 32'h0, 32'h0, KIND_COMMAND)};
    plan = {plan, make_row('0, 0, 1, 8'h11, 32'h18530906, 8'd5, 64'hCAFE0000BEEF1111, 16'h0,
                           0, '0, '0, '0, '0, KIND_UNKNOWN)};
    // broken header, then a stray AA ahead of the real one
    plan = {plan, make_row(64'hAA550103AA, 5, 1, 8'h22, ID_SPEED_BATT, 8'd6,
                           64'h8877665544332211, 16'h0, 0, '0, '0, '0, '0, KIND_UNKNOWN)};
    // sync pattern inside the frame is plain data
    plan = {plan, make_row('0, 0, 1, 8'hAA, 32'h020155AA, 8'd8, 64'h020155AA020155AA, 16'h0201,
                           0, '0, '0, '0, '0, KIND_UNKNOWN)};
    // frame ends on AA 55 01, next byte 02 must not open a frame
    plan = {plan, make_row('0, 0, 1, 8'h00, ID_AC_TEMP, 8'd8, 64'hAA00000000000000, 16'h0155,
                           0, '0, '0, '0, '0, KIND_UNKNOWN)};
    plan = {plan, make_row(64'h02, 1, 1, 8'h00, ID_FAULT, 8'd2, 64'h0000000000009876, 16'h0,
                           0, '0, '0, '0, '0, KIND_UNKNOWN)};
    plan = {plan, make_row(64'hAA5501, 3, 0, '0, '0, '0, '0, '0,
                           0, '0, '0, '0, '0, KIND_UNKNOWN)};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_row(plan[i]);
    while (bytes_sent < TOTAL_BYTES)
      send_row(random_row());

    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sync_header_frame_deframer");
    end else begin
      $display("FAIL sync_header_frame_deframer");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/shfd_pkg.sv
rtl/sync_header_frame_deframer.sv
tb/tb_sync_header_frame_deframer.sv
